FILE: hdl/mpbm_pkg.sv
`timescale 1ns / 1ps
package mpbm_pkg;

  localparam int MAX_WORDS    = 16;
  localparam int MAX_WORD_LEN = 64;

  localparam int BYTE_W  = 8;
  localparam int WIDX_W  = 4;
  localparam int OFF_W   = 32;
  localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
  localparam int POS_W   = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_WORDS + 1);
  localparam int KIDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int BDEPTH  = MAX_WORDS * MAX_WORD_LEN;
  localparam int BADDR_W = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  // head + L - len + i stays below 2L
  localparam int RPOS_W  = LEN_W + 1;

  localparam logic [OFF_W-1:0] OFF_MAX = '1;

  typedef enum logic [1:0] {
    ACT_LOAD     = 2'd0,
    ACT_SCAN     = 2'd1,
    ACT_NEW_TEXT = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WORD,
    ST_CMP,
    ST_HIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic accept;
    logic skip_word;
    logic start_word;
    logic cmp_step;
    logic take_hit;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic scan_req;
    logic word_done;
    logic word_skip;
    logic cmp_miss;
    logic cmp_hit;
    logic out_free;
    logic pend_vld;
  } sts_t;

endpackage

FILE: hdl/mpbm_in_if.sv
`timescale 1ns / 1ps
interface mpbm_in_if;
  import mpbm_pkg::*;

  logic                valid;
  logic                ready;
  action_t             action;
  logic [BYTE_W-1:0]   data_byte;
  logic                word_end;

  modport source (output valid, output action, output data_byte, output word_end,
                  input ready);
  modport sink   (input valid, input action, input data_byte, input word_end,
                  output ready);
endinterface

FILE: hdl/mpbm_out_if.sv
`timescale 1ns / 1ps
interface mpbm_out_if;
  import mpbm_pkg::*;

  logic                valid;
  logic                ready;
  logic [WIDX_W-1:0]   word_index;
  logic [OFF_W-1:0]    start_offset;
  logic                last;

  modport source (output valid, output word_index, output start_offset, output last,
                  input ready);
  modport sink   (input valid, input word_index, input start_offset, input last,
                  output ready);
endinterface

FILE: hdl/multi_pattern_byte_matcher.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    action, data_byte, word_end
// out_ch    out  valid/ready    word_index, start_offset, last
//
// Load, new-text and clear requests are taken in the idle state; a scan request
// walks every stored word, skipping it or comparing it byte by byte, with a
// hit-taking step on a hit; a compare runs at one byte compare per cycle.
// Synchronous active-low reset clears counters and valid flags only.
// A stalled out_ch holds the search at the next hit; the final result of a
// text byte waits in the output register while the next request is taken.
module multi_pattern_byte_matcher (
  input logic        clk,
  input logic        rst_n,
  mpbm_in_if.sink    in_ch,
  mpbm_out_if.source out_ch
);
  import mpbm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_rdy;

  // sequencer: walks the word list for each text byte
  mpbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  // dictionary, history ring, compare and result registers
  mpbm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_ch.action),
    .in_data_byte     (in_ch.data_byte),
    .in_word_end      (in_ch.word_end),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_word_index   (out_ch.word_index),
    .out_start_offset (out_ch.start_offset),
    .out_last         (out_ch.last),
    .cmd              (cmd),
    .sts              (sts)
  );

  assign in_ch.ready = in_rdy;

`ifndef SYNTHESIS
  // a held-back hit never survives the end of its text byte
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_rdy |-> !sts.pend_vld)
    else $error("pending hit left when ready for a new request");

  // moving a held-back hit out needs a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_hit && sts.pend_vld) || cmd.flush |-> sts.out_free)
    else $error("output register overwritten");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.skip_word, cmd.start_word, cmd.take_hit, cmd.flush}))
    else $error("conflicting commands");

  // a flush always ends the text byte
  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> in_rdy)
    else $error("flush did not return to idle");
`endif
endmodule

FILE: hdl/mpbm_ram.sv
`timescale 1ns / 1ps
module mpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: hdl/mpbm_ctrl.sv
`timescale 1ns / 1ps
module mpbm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mpbm_pkg::sts_t sts,
  output mpbm_pkg::cmd_t cmd
);
  import mpbm_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   slot_free;

  assign slot_free = !sts.pend_vld || sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.scan_req) begin
          state_nxt = ST_WORD;
        end
      end
      ST_WORD: begin
        if (sts.word_done) begin
          state_nxt = ST_FLUSH;
        end else if (!sts.word_skip) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.cmp_miss) begin
          state_nxt = ST_WORD;
        end else if (sts.cmp_hit) begin
          state_nxt = ST_HIT;
        end
      end
      ST_HIT: begin
        if (slot_free) begin
          state_nxt = ST_WORD;
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_WORD: begin
        if (!sts.word_done) begin
          cmd.skip_word  = sts.word_skip;
          cmd.start_word = !sts.word_skip;
        end
      end
      ST_CMP: begin
        cmd.cmp_step  = 1'b1;
        cmd.skip_word = sts.cmp_miss;
      end
      ST_HIT: begin
        cmd.take_hit = slot_free;
      end
      ST_FLUSH: begin
        cmd.flush = sts.pend_vld && sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end
endmodule

FILE: hdl/mpbm_dp.sv
`timescale 1ns / 1ps
module mpbm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpbm_pkg::action_t             in_action,
  input  logic [mpbm_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                          in_word_end,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [mpbm_pkg::WIDX_W-1:0]   out_word_index,
  output logic [mpbm_pkg::OFF_W-1:0]    out_start_offset,
  output logic                          out_last,
  input  mpbm_pkg::cmd_t                cmd,
  output mpbm_pkg::sts_t                sts
);
  import mpbm_pkg::*;

  // dictionary state
  logic [CNT_W-1:0]   word_count_r;
  logic [LEN_W-1:0]   fill_length_r;
  logic [LEN_W-1:0]   lengths_r [MAX_WORDS];
  // text state
  logic [POS_W-1:0]   ring_head_r;
  logic [OFF_W-1:0]   text_offset_r;
  logic [OFF_W-1:0]   cur_off_r;
  // search
  logic [CNT_W-1:0]   k_r;
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   i_r;
  logic               rd_vld_r;
  logic               rd_last_r;
  // one hit held back until we know whether it is the last
  logic               pend_vld_r;
  logic [WIDX_W-1:0]  pend_idx_r;
  logic [OFF_W-1:0]   pend_off_r;
  // output register
  logic               out_vld_r;
  logic [WIDX_W-1:0]  out_idx_r;
  logic [OFF_W-1:0]   out_off_r;
  logic               out_last_r;

  logic [KIDX_W-1:0]  k_idx;
  logic [KIDX_W-1:0]  wc_idx;
  logic [LEN_W-1:0]   cur_len;
  logic               is_load;
  logic               is_scan;
  logic               can_store;
  logic               fill_room;
  logic [LEN_W-1:0]   fill_inc;
  logic               word_we;
  logic [BADDR_W-1:0] word_waddr;
  logic [BADDR_W-1:0] word_raddr;
  logic [BYTE_W-1:0]  word_q;
  logic [RPOS_W-1:0]  ring_pos;
  logic [POS_W-1:0]   ring_raddr;
  logic [BYTE_W-1:0]  ring_q;
  logic               ring_we;
  logic               cmp_eq;
  logic               cmp_stop;
  logic               issue;
  logic [OFF_W-1:0]   hit_off;
  logic               out_load;
  logic               out_free;

  assign k_idx  = KIDX_W'(k_r);
  assign wc_idx = KIDX_W'(word_count_r);
  assign cur_len = lengths_r[k_idx];

  assign is_load   = cmd.accept && (in_action == ACT_LOAD);
  assign is_scan   = cmd.accept && (in_action == ACT_SCAN);
  assign can_store = word_count_r < CNT_W'(MAX_WORDS);
  assign fill_room = fill_length_r < LEN_W'(MAX_WORD_LEN);
  assign fill_inc  = fill_room ? fill_length_r + LEN_W'(1) : fill_length_r;
  assign word_we   = is_load && can_store && fill_room;
  assign word_waddr = BADDR_W'(wc_idx) * BADDR_W'(MAX_WORD_LEN) + BADDR_W'(fill_length_r);
  assign word_raddr = BADDR_W'(k_idx) * BADDR_W'(MAX_WORD_LEN) + BADDR_W'(i_r);

  // slot of byte i of a len-byte window ending at the newest byte
  assign ring_pos = RPOS_W'(ring_head_r) + RPOS_W'(MAX_WORD_LEN) - RPOS_W'(len_r)
                  + RPOS_W'(i_r);
  assign ring_raddr = (ring_pos >= RPOS_W'(MAX_WORD_LEN))
                    ? POS_W'(ring_pos - RPOS_W'(MAX_WORD_LEN)) : POS_W'(ring_pos);
  assign ring_we = is_scan;

  mpbm_ram #(.WIDTH(BYTE_W), .DEPTH(BDEPTH)) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (in_data_byte),
    .raddr (word_raddr),
    .rdata (word_q)
  );

  mpbm_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_WORD_LEN)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_head_r),
    .wdata (in_data_byte),
    .raddr (ring_raddr),
    .rdata (ring_q)
  );

  assign cmp_eq   = (ring_q == word_q);
  assign sts.cmp_miss = rd_vld_r && !cmp_eq;
  assign sts.cmp_hit  = rd_vld_r && rd_last_r && cmp_eq;
  assign cmp_stop = sts.cmp_miss || sts.cmp_hit;
  assign issue    = cmd.cmp_step && !cmp_stop && (i_r < len_r);

  assign hit_off  = cur_off_r - OFF_W'(len_r) + OFF_W'(1);
  assign out_load = cmd.flush || (cmd.take_hit && pend_vld_r);
  assign out_free = !out_vld_r || out_ready;

  assign sts.scan_req  = (in_action == ACT_SCAN);
  assign sts.word_done = (k_r >= word_count_r);
  assign sts.word_skip = cur_off_r < (OFF_W'(cur_len) - OFF_W'(1));
  assign sts.out_free  = out_free;
  assign sts.pend_vld  = pend_vld_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r  <= '0;
      fill_length_r <= '0;
      ring_head_r   <= '0;
      text_offset_r <= '0;
      k_r           <= '0;
      i_r           <= '0;
      rd_vld_r      <= 1'b0;
      pend_vld_r    <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (is_load) begin
        if (in_word_end) begin
          if (can_store && (fill_inc != '0)) begin
            word_count_r <= word_count_r + CNT_W'(1);
          end
          fill_length_r <= '0;
        end else if (can_store) begin
          fill_length_r <= fill_inc;
        end
      end
      if (cmd.accept && (in_action == ACT_CLEAR)) begin
        word_count_r  <= '0;
        fill_length_r <= '0;
      end
      if (cmd.accept && (in_action == ACT_NEW_TEXT)) begin
        ring_head_r   <= '0;
        text_offset_r <= '0;
      end
      if (is_scan) begin
        ring_head_r <= (ring_head_r == POS_W'(MAX_WORD_LEN - 1))
                     ? '0 : ring_head_r + POS_W'(1);
        if (text_offset_r != OFF_MAX) begin
          text_offset_r <= text_offset_r + OFF_W'(1);
        end
        k_r <= '0;
      end
      if (cmd.skip_word || cmd.take_hit) begin
        k_r <= k_r + CNT_W'(1);
      end
      if (cmd.start_word) begin
        i_r <= '0;
      end else if (issue) begin
        i_r <= i_r + LEN_W'(1);
      end
      rd_vld_r <= issue;
      if (cmd.take_hit) begin
        pend_vld_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (is_load && in_word_end && can_store && (fill_inc != '0)) begin
      lengths_r[wc_idx] <= fill_inc;
    end
    if (is_scan) begin
      cur_off_r <= text_offset_r;
    end
    if (cmd.start_word) begin
      len_r <= cur_len;
    end
    rd_last_r <= (i_r == len_r - LEN_W'(1));
    if (cmd.take_hit) begin
      pend_idx_r <= WIDX_W'(k_r);
      pend_off_r <= hit_off;
    end
    if (out_load) begin
      out_idx_r  <= pend_idx_r;
      out_off_r  <= pend_off_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_word_index   = out_idx_r;
  assign out_start_offset = out_off_r;
  assign out_last         = out_last_r;
endmodule
